[rtl/power_output_supervisor_macros.svh]
// Assertion macros for the supervisor checker
`ifndef POWER_OUTPUT_SUPERVISOR_MACROS_SVH
`define POWER_OUTPUT_SUPERVISOR_MACROS_SVH

`define POS_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define POS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[rtl/pos_pkg.sv]
`default_nettype none
package pos_pkg;
   localparam int KIND_SETVI  = 0;
   localparam int KIND_OUTPUT = 1;
   localparam int KIND_LIMITS = 2;
   localparam int KIND_RESET  = 3;
   localparam int KIND_HBEAT  = 4;
   localparam int KIND_HWEN   = 5;
   localparam int KIND_TEMP   = 6;
   localparam int KIND_FAULT  = 7;
   localparam int KIND_TICK   = 8;

   localparam int REG_MAX_V   = 0;
   localparam int REG_MAX_I   = 1;
   localparam int REG_MAX_P   = 2;
   localparam int REG_RAMP    = 3;
   localparam int REG_DR_BEG  = 4;
   localparam int REG_DR_END  = 5;
   localparam int REG_HB_TO   = 6;

   localparam logic [1:0] ST_SAFE   = 2'd0;
   localparam logic [1:0] ST_ACTIVE = 2'd1;
   localparam logic [1:0] ST_FAULT  = 2'd2;

   localparam logic [7:0] RST_REBOOT = 8'd1;
   localparam logic [7:0] RST_CLEAR  = 8'd2;

   localparam int DIV_W = 64;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_EXEC, SEQ_ENV, SEQ_CLAMP, SEQ_DER, SEQ_QUO, SEQ_DONE
   } seq_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

[rtl/pos_divider.sv]
`default_nettype none
module pos_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pos_pkg::div_req_type req,
   output pos_pkg::div_rsp_type      rsp
);
   localparam int W = pos_pkg::DIV_W;
   logic [W-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [W:0]   trial;
   logic [W-1:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-2:0], quo_ff[W-1]};
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 7'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

[rtl/power_output_supervisor.sv]
// Channel  Dir  Handshake        Content
// req      in   tvalid/tready    event item, kind in tuser
// rsp      out  tvalid/tready    status item
// csr      in   wr_en            register index and value
// Setpoint and limit kinds take one 64-step shared divider pass (skipped at
// 1000 uV or below), and a temperature-derated status takes a second pass;
// other kinds take one derating pass only when the output is closed and at or
// above the derate start.
// Synchronous reset restores CSR and status defaults, not the work registers.
// req_tready is low from acceptance until the result item is taken; a stalled
// rsp_tready holds the result.
`default_nettype none
module power_output_supervisor #(
   parameter int MODE_MAX = 3
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [3:0]   req_tuser,  // kind
   // voltage_uv, current_ua, out_mode_req, power_limit_mw, derate_limit_dc,
   // hold_policy, reset_code, hw_enabled, temperature_dc, fault_mask,
   // elapsed_ms, zero fill
   input  wire logic [159:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // accepted, state_code, mode_now, voltage_set_uv, current_set_ua,
   // voltage_ref_uv, current_ref_ua, warnings, faults, reboot_request
   output logic [119:0]      rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_index,
   input  wire logic [26:0]  csr_data
);
   localparam int MW = $clog2(MODE_MAX + 1);

   logic [25:0] maxv_ff; logic [24:0] maxi_ff; logic [19:0] maxp_ff;
   logic [26:0] ramp_ff; logic signed [11:0] drb_ff, dre_ff; logic [19:0] hbto_ff;

   logic [1:0] st_ff, st_in; logic [2:0] mode_ff, mode_in;
   logic [25:0] vset_ff, vset_in, vref_ff, vref_in; logic [24:0] iset_ff, iset_in;
   logic [19:0] plim_ff, plim_in; logic signed [11:0] dst_ff, dst_in;
   logic [1:0] pol_ff, pol_in; logic en_ff, en_in;
   logic signed [15:0] temp_ff, temp_in; logic [31:0] sil_ff, sil_in;
   logic [2:0] warn_ff, warn_in; logic [7:0] flt_ff, flt_in; logic reb_ff, reb_in;
   logic acc_ff, acc_in; logic [24:0] iref_ff, iref_in;

   pos_pkg::seq_type seq_ff, seq_in;
   logic [3:0]   kind_ff;
   logic [159:0] dat_ff;
   logic signed [32:0] vreq_ff, vreq_in, ireq_ff, ireq_in;
   logic [25:0] vcl_ff, vcl_in;
   logic [47:0] prod_ff, prod_in;

   pos_pkg::div_req_type dreq;
   pos_pkg::div_rsp_type drsp;
   pos_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic signed [31:0] f_v, f_i; logic [7:0] f_m; logic [19:0] f_p;
   logic signed [11:0] f_dl; logic [1:0] f_hp; logic [7:0] f_rc; logic f_hw;
   logic signed [15:0] f_t; logic [7:0] f_fm; logic [15:0] f_dt;
   assign f_v = req_tdata[31:0];   assign f_i  = req_tdata[63:32];
   assign f_m = req_tdata[71:64];  assign f_p  = req_tdata[91:72];
   assign f_dl = req_tdata[103:92]; assign f_hp = req_tdata[105:104];
   assign f_rc = req_tdata[113:106]; assign f_hw = req_tdata[114];
   assign f_t = req_tdata[130:115]; assign f_fm = req_tdata[138:131];
   assign f_dt = req_tdata[154:139];

   logic closed_w, der_need;
   logic signed [16:0] span_w, left_w;
   logic [31:0] sil_add;
   logic [43:0] step_w;
   logic [63:0] ilim;
   logic [26:0] vup, vdn;
   logic signed [32:0] icl;
   assign closed_w = st_ff == pos_pkg::ST_ACTIVE && mode_ff != 3'd0;
   assign span_w = 17'(dre_ff) - 17'(dst_ff);
   assign left_w = 17'(dre_ff) - 17'(temp_ff);
   assign der_need = closed_w && 17'(temp_ff) >= 17'(dst_ff);

   always_comb begin
      seq_in = seq_ff; st_in = st_ff; mode_in = mode_ff; vset_in = vset_ff;
      iset_in = iset_ff; vref_in = vref_ff; plim_in = plim_ff; dst_in = dst_ff;
      pol_in = pol_ff; en_in = en_ff; temp_in = temp_ff; sil_in = sil_ff;
      warn_in = warn_ff; flt_in = flt_ff; reb_in = reb_ff; acc_in = acc_ff;
      iref_in = iref_ff; vreq_in = vreq_ff; ireq_in = ireq_ff; vcl_in = vcl_ff;
      prod_in = prod_ff; dreq = '0;
      sil_add = '0; step_w = '0; ilim = '0; vup = '0; vdn = '0; icl = '0;
      case (seq_ff)
         pos_pkg::SEQ_IDLE: if (req_tvalid) seq_in = pos_pkg::SEQ_EXEC;
         pos_pkg::SEQ_EXEC: begin
            acc_in = 1'b1;
            seq_in = pos_pkg::SEQ_DER;
            case (kind_ff)
               4'(pos_pkg::KIND_SETVI): begin
                  vreq_in = 33'(signed'(dat_ff[31:0]));
                  ireq_in = 33'(signed'(dat_ff[63:32]));
                  seq_in = pos_pkg::SEQ_ENV;
               end
               4'(pos_pkg::KIND_OUTPUT): begin
                  if (dat_ff[71:64] > 8'(MODE_MAX)) acc_in = 1'b0;
                  else if (dat_ff[71:64] == 8'd0) begin
                     if (st_ff == pos_pkg::ST_ACTIVE) st_in = pos_pkg::ST_SAFE;
                     mode_in = '0; vref_in = '0;
                  end else if (st_ff == pos_pkg::ST_FAULT || !en_ff) acc_in = 1'b0;
                  else begin
                     mode_in = 3'(dat_ff[64 +: MW]); st_in = pos_pkg::ST_ACTIVE;
                  end
               end
               4'(pos_pkg::KIND_LIMITS): begin
                  if (dat_ff[91:72] != 20'd0 && dat_ff[91:72] < plim_ff)
                     plim_in = dat_ff[91:72];
                  if ($signed(dat_ff[103:92]) > 12'sd0 && $signed(dat_ff[103:92]) < dst_ff)
                     dst_in = dat_ff[103:92];
                  pol_in = dat_ff[105:104];
                  vreq_in = 33'(vset_ff); ireq_in = 33'(iset_ff);
                  seq_in = pos_pkg::SEQ_ENV;
               end
               4'(pos_pkg::KIND_RESET): begin
                  if (dat_ff[113:106] == pos_pkg::RST_REBOOT) reb_in = 1'b1;
                  else if (dat_ff[113:106] == pos_pkg::RST_CLEAR && st_ff == pos_pkg::ST_FAULT) begin
                     flt_in = '0; st_in = pos_pkg::ST_SAFE;
                  end
               end
               4'(pos_pkg::KIND_HBEAT): begin sil_in = '0; warn_in[2] = 1'b0; end
               4'(pos_pkg::KIND_HWEN): begin
                  en_in = dat_ff[114];
                  if (!dat_ff[114] && st_ff == pos_pkg::ST_ACTIVE) begin
                     st_in = pos_pkg::ST_SAFE; mode_in = '0; vref_in = '0;
                  end
               end
               4'(pos_pkg::KIND_TEMP): begin
                  temp_in = dat_ff[130:115];
                  warn_in[1] = 17'($signed(dat_ff[130:115])) >= 17'(dst_ff);
                  if (17'($signed(dat_ff[130:115])) >= 17'(dre_ff)) begin
                     flt_in = flt_ff | 8'd1; st_in = pos_pkg::ST_FAULT;
                     mode_in = '0; vref_in = '0;
                  end
               end
               4'(pos_pkg::KIND_FAULT): begin
                  flt_in = flt_ff | dat_ff[138:131]; st_in = pos_pkg::ST_FAULT;
                  mode_in = '0; vref_in = '0;
               end
               4'(pos_pkg::KIND_TICK): begin
                  sil_add = sil_ff;
                  if (sil_ff <= 32'(hbto_ff)) sil_add = sil_ff + 32'(dat_ff[154:139]);
                  sil_in = sil_add;
                  if (sil_add > 32'(hbto_ff)) begin
                     warn_in[2] = 1'b1;
                     if (pol_ff == 2'd0 && st_ff == pos_pkg::ST_ACTIVE) begin
                        st_in = pos_pkg::ST_SAFE; mode_in = '0;
                     end
                  end
                  step_w = 44'(ramp_ff) * 44'(dat_ff[154:139]);
                  if (st_in == pos_pkg::ST_ACTIVE) begin
                     vup = 27'(vref_ff) + 27'(step_w);
                     vdn = 27'(vref_ff) - 27'(step_w);
                     if (vref_ff < vset_ff)
                        vref_in = (step_w >= 44'(vset_ff - vref_ff)) ? vset_ff : vup[25:0];
                     else if (vref_ff > vset_ff)
                        vref_in = (step_w >= 44'(vref_ff - vset_ff)) ? vset_ff : vdn[25:0];
                  end else vref_in = '0;
               end
               default: ;
            endcase
         end
         pos_pkg::SEQ_ENV: begin
            if (vreq_ff < 33'sd0) vcl_in = '0;
            else if (vreq_ff > 33'(maxv_ff)) vcl_in = maxv_ff;
            else vcl_in = vreq_ff[25:0];
            dreq.start    = 1'b1;
            dreq.dividend = 64'(plim_ff) * 64'd1000000000;
            dreq.divisor  = 64'(vcl_in);
            seq_in = pos_pkg::SEQ_CLAMP;
         end
         pos_pkg::SEQ_CLAMP: if (drsp.done || vcl_ff <= 26'd1000) begin
            ilim = 64'(maxi_ff);
            if (vcl_ff > 26'd1000 && drsp.quotient < ilim) ilim = drsp.quotient;
            if (ireq_ff < 33'sd0) icl = '0;
            else if (64'(ireq_ff) > ilim) icl = 33'(ilim);
            else icl = ireq_ff;
            warn_in[0] = (33'(vcl_ff) != vreq_ff) || (icl != ireq_ff);
            vset_in = vcl_ff; iset_in = icl[24:0];
            seq_in = pos_pkg::SEQ_DER;
         end
         pos_pkg::SEQ_DER: begin
            iref_in = closed_w ? iset_ff : '0;
            prod_in = 48'(iset_ff) * 48'(left_w[15:0]);
            if (der_need) begin
               if (left_w <= 17'sd0 || span_w <= 17'sd0) begin
                  iref_in = '0; seq_in = pos_pkg::SEQ_DONE;
               end else begin
                  dreq.start = 1'b1;
                  dreq.dividend = 64'(prod_in);
                  dreq.divisor = 64'(span_w[15:0]);
                  seq_in = pos_pkg::SEQ_QUO;
               end
            end else seq_in = pos_pkg::SEQ_DONE;
         end
         pos_pkg::SEQ_QUO: if (drsp.done) begin
            iref_in = drsp.quotient[24:0];
            seq_in = pos_pkg::SEQ_DONE;
         end
         pos_pkg::SEQ_DONE: if (rsp_tready) seq_in = pos_pkg::SEQ_IDLE;
         default: seq_in = pos_pkg::SEQ_IDLE;
      endcase
      if (csr_wr_en && csr_index == 3'(pos_pkg::REG_MAX_P)) plim_in = csr_data[19:0];
      if (csr_wr_en && csr_index == 3'(pos_pkg::REG_DR_BEG)) dst_in = csr_data[11:0];
   end

   assign req_tready = seq_ff == pos_pkg::SEQ_IDLE;
   assign rsp_tvalid = seq_ff == pos_pkg::SEQ_DONE;
   assign rsp_tdata = {reb_ff, flt_ff, warn_ff, iref_ff,
                       closed_w ? vref_ff : 26'd0, iset_ff, vset_ff, mode_ff, st_ff, acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= pos_pkg::SEQ_IDLE;
         maxv_ff <= 26'd20000000; maxi_ff <= 25'd8000000; maxp_ff <= 20'd150000;
         ramp_ff <= 27'd1000000; drb_ff <= 12'sd850; dre_ff <= 12'sd1000;
         hbto_ff <= 20'd3000;
         st_ff <= pos_pkg::ST_SAFE; mode_ff <= '0; vset_ff <= '0; iset_ff <= '0;
         vref_ff <= '0; plim_ff <= 20'd150000; dst_ff <= 12'sd850; pol_ff <= '0;
         en_ff <= 1'b0; temp_ff <= '0; sil_ff <= '0; warn_ff <= '0; flt_ff <= '0;
         reb_ff <= 1'b0; iref_ff <= '0;
      end else begin
         seq_ff <= seq_in; st_ff <= st_in; mode_ff <= mode_in; vset_ff <= vset_in;
         iset_ff <= iset_in; vref_ff <= vref_in; plim_ff <= plim_in; dst_ff <= dst_in;
         pol_ff <= pol_in; en_ff <= en_in; temp_ff <= temp_in; sil_ff <= sil_in;
         warn_ff <= warn_in; flt_ff <= flt_in; reb_ff <= reb_in; iref_ff <= iref_in;
         if (csr_wr_en) begin
            case (csr_index)
               3'(pos_pkg::REG_MAX_V): maxv_ff <= csr_data[25:0];
               3'(pos_pkg::REG_MAX_I): maxi_ff <= csr_data[24:0];
               3'(pos_pkg::REG_MAX_P): maxp_ff <= csr_data[19:0];
               3'(pos_pkg::REG_RAMP): ramp_ff <= csr_data;
               3'(pos_pkg::REG_DR_BEG): drb_ff <= csr_data[11:0];
               3'(pos_pkg::REG_DR_END): dre_ff <= csr_data[11:0];
               3'(pos_pkg::REG_HB_TO): hbto_ff <= csr_data[19:0];
               default: ;
            endcase
         end
      end
      acc_ff <= acc_in; vreq_ff <= vreq_in; ireq_ff <= ireq_in;
      vcl_ff <= vcl_in; prod_ff <= prod_in;
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser; dat_ff <= req_tdata;
      end
   end

   logic unused_ok;
   assign unused_ok = ^{drb_ff, maxp_ff, prod_ff, f_v, f_i, f_m, f_p, f_dl, f_hp,
                        f_rc, f_hw, f_t, f_fm, f_dt, dat_ff[159:155]};
endmodule
`default_nettype wire

[rtl/pos_checker.sv]
`default_nettype none
`include "power_output_supervisor_macros.svh"
module pos_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [119:0] rsp_tdata
);
   `POS_ASSERT_IMP(a_excl, clock, reset, rsp_tvalid, !req_tready, "ready while result pending")
   `POS_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "ready after accept")
   `POS_ASSERT_IMP(a_state, clock, reset, rsp_tvalid, rsp_tdata[2:1] != 2'd3, "bad state code")
   `POS_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
endmodule
bind power_output_supervisor pos_checker u_pos_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire
